// ===== design/assert_macros.svh =====
// assertion macros used by the twofish core
// clocked on clock, disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TF_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/tf_pkg.sv =====
// twofish shared types, tables and the h function
// used by the key schedule, the round cells and the top level
package tf_pkg;

   localparam int NUM_ROUNDS    = 16;
   localparam int NUM_SUBKEYS   = 40;
   localparam int NUM_KEY_PAIRS = 20;
   localparam int CSR_IDX_W     = 3;
   localparam int MAX_KEY_BYTES = 32;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_3     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LENGTH     = 3'd4;

   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;
   localparam logic [1:0] KEY_256 = 2'd2;

   localparam logic [8:0] MDS_POLY = 9'h169;
   localparam logic [8:0] RS_POLY  = 9'h14D;

   localparam logic [3:0] Q_TAB [2][4][16] = '{
      '{
         '{4'h8,4'h1,4'h7,4'hD,4'h6,4'hF,4'h3,4'h2,4'h0,4'hB,4'h5,4'h9,4'hE,4'hC,4'hA,4'h4},
         '{4'hE,4'hC,4'hB,4'h8,4'h1,4'h2,4'h3,4'h5,4'hF,4'h4,4'hA,4'h6,4'h7,4'h0,4'h9,4'hD},
         '{4'hB,4'hA,4'h5,4'hE,4'h6,4'hD,4'h9,4'h0,4'hC,4'h8,4'hF,4'h3,4'h2,4'h4,4'h7,4'h1},
         '{4'hD,4'h7,4'hF,4'h4,4'h1,4'h2,4'h6,4'hE,4'h9,4'hB,4'h3,4'h0,4'h8,4'h5,4'hC,4'hA}
      },
      '{
         '{4'h2,4'h8,4'hB,4'hD,4'hF,4'h7,4'h6,4'hE,4'h3,4'h1,4'h9,4'h4,4'h0,4'hA,4'hC,4'h5},
         '{4'h1,4'hE,4'h2,4'hB,4'h4,4'hC,4'h3,4'h7,4'h6,4'hD,4'hA,4'h5,4'hF,4'h9,4'h0,4'h8},
         '{4'h4,4'hC,4'h7,4'h5,4'h1,4'h6,4'h9,4'hA,4'h0,4'hE,4'hD,4'h8,4'h2,4'hB,4'h3,4'hF},
         '{4'hB,4'h9,4'h5,4'h1,4'hC,4'h3,4'hD,4'hE,4'h6,4'h4,4'h7,4'hF,4'h2,4'h0,4'h8,4'hA}
      }
   };

   localparam logic [7:0] MDS_M [4][4] = '{
      '{8'h01,8'hEF,8'h5B,8'h5B},
      '{8'h5B,8'hEF,8'hEF,8'h01},
      '{8'hEF,8'h5B,8'h01,8'hEF},
      '{8'hEF,8'h01,8'hEF,8'h5B}
   };

   localparam logic [7:0] RS_M [4][8] = '{
      '{8'h01,8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E},
      '{8'hA4,8'h56,8'h82,8'hF3,8'h1E,8'hC6,8'h68,8'hE5},
      '{8'h02,8'hA1,8'hFC,8'hC1,8'h47,8'hAE,8'h3D,8'h19},
      '{8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E,8'h03}
   };

   typedef struct packed {
      logic             op;
      logic [3:0][31:0] w;
   } stage_type;

   typedef struct packed {
      logic             valid;
      logic             busy;
      logic [1:0]       kcode;
      logic [3:0][31:0] sbox;
   } key_state_type;

   function automatic logic [3:0] nib_ror(input logic [3:0] b);
      return {b[0], b[3:1]};
   endfunction

   function automatic logic [7:0] qperm(input logic w, input logic [7:0] x);
      logic [3:0] a1, b1, a2, b2, a3, b3, a4, b4;
      a1 = x[7:4] ^ x[3:0];
      b1 = x[7:4] ^ nib_ror(x[3:0]) ^ {x[4], 3'b000};
      a2 = Q_TAB[w][0][a1];
      b2 = Q_TAB[w][1][b1];
      a3 = a2 ^ b2;
      b3 = a2 ^ nib_ror(b2) ^ {a2[0], 3'b000};
      a4 = Q_TAB[w][2][a3];
      b4 = Q_TAB[w][3][b3];
      return {b4, a4};
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                         input logic [8:0] poly);
      logic [7:0] r;
      logic [8:0] aa;
      r  = 8'h00;
      aa = {1'b0, a};
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            r = r ^ aa[7:0];
         end
         aa = {aa[7:0], 1'b0};
         if (aa[8]) begin
            aa = aa ^ poly;
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] h_fn(input logic [31:0] x, input logic [31:0] l0,
                                        input logic [31:0] l1, input logic [31:0] l2,
                                        input logic [31:0] l3, input logic [1:0] kcode);
      logic [7:0]  y [4];
      logic [7:0]  acc;
      logic [31:0] z;
      for (int j = 0; j < 4; j++) begin
         y[j] = x[8*j +: 8];
      end
      if (kcode == KEY_256) begin
         y[0] = qperm(1'b1, y[0]) ^ l3[7:0];
         y[1] = qperm(1'b0, y[1]) ^ l3[15:8];
         y[2] = qperm(1'b0, y[2]) ^ l3[23:16];
         y[3] = qperm(1'b1, y[3]) ^ l3[31:24];
      end
      if (kcode == KEY_256 || kcode == KEY_192) begin
         y[0] = qperm(1'b1, y[0]) ^ l2[7:0];
         y[1] = qperm(1'b1, y[1]) ^ l2[15:8];
         y[2] = qperm(1'b0, y[2]) ^ l2[23:16];
         y[3] = qperm(1'b0, y[3]) ^ l2[31:24];
      end
      y[0] = qperm(1'b1, qperm(1'b0, qperm(1'b0, y[0]) ^ l1[7:0]) ^ l0[7:0]);
      y[1] = qperm(1'b0, qperm(1'b0, qperm(1'b1, y[1]) ^ l1[15:8]) ^ l0[15:8]);
      y[2] = qperm(1'b1, qperm(1'b1, qperm(1'b0, y[2]) ^ l1[23:16]) ^ l0[23:16]);
      y[3] = qperm(1'b0, qperm(1'b1, qperm(1'b1, y[3]) ^ l1[31:24]) ^ l0[31:24]);
      z = 32'h0;
      for (int i = 0; i < 4; i++) begin
         acc = 8'h00;
         for (int j = 0; j < 4; j++) begin
            acc = acc ^ gf_mul(MDS_M[i][j], y[j], MDS_POLY);
         end
         z[8*i +: 8] = acc;
      end
      return z;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== design/twofish_block_cipher_core.sv =====
// Twofish ECB core: takes one 128-bit block per cycle while rsp_tready and
// the key schedule allow, and returns it encrypted or decrypted through its
// input whitening register, sixteen round cells and output register; each
// round cell holds one round's g functions and adders. After reset and after
// any key register write the key schedule runs, one subkey pair a cycle, and
// no item is accepted until it is done. Uses tf_pkg, tf_key_sched and
// tf_round_cell.
`include "assert_macros.svh"

module twofish_block_cipher_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [127:0]                 req_tdata,  // block_low, block_high
   input  logic                         req_tuser,  // op
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [127:0]                 rsp_tdata,  // result_low, result_high
   input  logic                         csr_we,
   input  logic [tf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                  csr_wdata
);

   tf_pkg::key_state_type ks;
   logic [39:0][31:0]     rk;

   logic                  in_v_ff;
   tf_pkg::stage_type     in_d_ff;
   tf_pkg::stage_type     in_d_in;
   logic                  in_rdy;

   logic                  cell_v   [17];
   tf_pkg::stage_type     cell_d   [17];
   logic                  cell_rdy [17];

   logic                  out_v_ff;
   logic [127:0]          out_d_ff;
   logic [127:0]          out_d_in;
   logic                  out_rdy;
   logic [3:0][31:0]      fin;

   tf_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .ks         (ks),
      .round_keys (rk)
   );

   // input whitening
   always_comb begin
      in_d_in.op = req_tuser;
      for (int i = 0; i < 4; i++) begin
         in_d_in.w[i] = req_tdata[32*i +: 32] ^ (req_tuser ? rk[4+i] : rk[i]);
      end
   end

   assign in_rdy     = !in_v_ff || cell_rdy[0];
   assign req_tready = in_rdy && ks.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (in_rdy) begin
         in_v_ff <= req_tvalid && ks.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_d_ff <= in_d_in;
      end
   end

   assign cell_v[0] = in_v_ff;
   assign cell_d[0] = in_d_ff;

   for (genvar r = 0; r < tf_pkg::NUM_ROUNDS; r++) begin : g_round
      tf_round_cell u_round (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (cell_v[r]),
         .in_data      (cell_d[r]),
         .in_ready     (cell_rdy[r]),
         .out_valid    (cell_v[r+1]),
         .out_data     (cell_d[r+1]),
         .out_ready    (cell_rdy[r+1]),
         .ks           (ks),
         .key_enc_even (rk[8+2*r]),
         .key_enc_odd  (rk[9+2*r]),
         .key_dec_even (rk[38-2*r]),
         .key_dec_odd  (rk[39-2*r])
      );
   end

   // output whitening and word swap
   always_comb begin
      fin = cell_d[16].w;
      if (cell_d[16].op) begin
         out_d_in = {fin[1] ^ rk[3], fin[0] ^ rk[2], fin[3] ^ rk[1], fin[2] ^ rk[0]};
      end else begin
         out_d_in = {fin[1] ^ rk[7], fin[0] ^ rk[6], fin[3] ^ rk[5], fin[2] ^ rk[4]};
      end
   end

   assign out_rdy      = !out_v_ff || rsp_tready;
   assign cell_rdy[16] = out_rdy;
   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = out_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_rdy) begin
         out_v_ff <= cell_v[16];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && cell_v[16]) begin
         out_d_ff <= out_d_in;
      end
   end

   `TF_ASSERT_IMP(a_accept_needs_keys, req_tvalid && req_tready, ks.valid)
   `TF_ASSERT_IMP(a_sched_blocks_input, ks.busy, !req_tready)
   `TF_ASSERT_NXT(a_key_write_stales, csr_we && csr_index <= tf_pkg::REG_KEY_LENGTH, !ks.valid)

endmodule

// ===== design/tf_key_sched.sv =====
// key registers and key schedule sequencer: one subkey pair per cycle,
// shifted into a 40-word chain; uses tf_pkg
module tf_key_sched (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                 csr_wdata,
   output tf_pkg::key_state_type       ks,
   output logic [39:0][31:0]           round_keys
);

   typedef enum logic [1:0] {ST_STALE, ST_RUN, ST_READY} state_type;

   state_type        state_ff;
   logic [4:0]       cnt_ff;
   logic [63:0]      key_ff [4];
   logic [5:0]       len_ff;
   logic [31:0]      rk_ff [40];
   logic [1:0]       kcode_ff;
   logic [3:0][31:0] sbox_ff;

   logic [5:0]       len_eff;
   logic [7:0]       kb [32];
   logic [31:0]      me [4];
   logic [31:0]      mo [4];
   logic [1:0]       kcode;
   logic [31:0]      rs [4];
   logic [3:0][31:0] sbox_in;
   logic [7:0]       acc;
   logic [31:0]      ha, hb, sum_ab, sum_a2b;

   always_comb begin
      len_eff = (len_ff > 6'(tf_pkg::MAX_KEY_BYTES)) ? 6'(tf_pkg::MAX_KEY_BYTES) : len_ff;
      for (int n = 0; n < 32; n++) begin
         kb[n] = (6'(n) < len_eff) ? key_ff[n / 8][8*(n % 8) +: 8] : 8'h00;
      end
      for (int i = 0; i < 4; i++) begin
         me[i] = {kb[8*i+3], kb[8*i+2], kb[8*i+1], kb[8*i]};
         mo[i] = {kb[8*i+7], kb[8*i+6], kb[8*i+5], kb[8*i+4]};
      end
      if (len_eff <= 6'd16) begin
         kcode = tf_pkg::KEY_128;
      end else if (len_eff <= 6'd24) begin
         kcode = tf_pkg::KEY_192;
      end else begin
         kcode = tf_pkg::KEY_256;
      end
      for (int i = 0; i < 4; i++) begin
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int c = 0; c < 8; c++) begin
               acc = acc ^ tf_pkg::gf_mul(tf_pkg::RS_M[r][c], kb[8*i+c], tf_pkg::RS_POLY);
            end
            rs[i][8*r +: 8] = acc;
         end
      end
      sbox_in = '0;
      unique case (kcode)
         tf_pkg::KEY_128: begin
            sbox_in[1] = rs[0];
            sbox_in[0] = rs[1];
         end
         tf_pkg::KEY_192: begin
            sbox_in[2] = rs[0];
            sbox_in[1] = rs[1];
            sbox_in[0] = rs[2];
         end
         default: begin
            sbox_in[3] = rs[0];
            sbox_in[2] = rs[1];
            sbox_in[1] = rs[2];
            sbox_in[0] = rs[3];
         end
      endcase
   end

   // subkey pair for index cnt
   always_comb begin
      ha = tf_pkg::h_fn({4{2'b00, cnt_ff, 1'b0}}, me[0], me[1], me[2], me[3], kcode_ff);
      hb = tf_pkg::rotl32(
              tf_pkg::h_fn({4{2'b00, cnt_ff, 1'b1}}, mo[0], mo[1], mo[2], mo[3], kcode_ff), 8);
      sum_ab  = ha + hb;
      sum_a2b = tf_pkg::rotl32(ha + {hb[30:0], 1'b0}, 9);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STALE;
         cnt_ff   <= '0;
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
         end
         len_ff   <= 6'd16;
      end else if (csr_we) begin
         priority case (csr_index)
            tf_pkg::REG_KEY_WORD_0,
            tf_pkg::REG_KEY_WORD_1,
            tf_pkg::REG_KEY_WORD_2,
            tf_pkg::REG_KEY_WORD_3: begin
               key_ff[csr_index[1:0]] <= csr_wdata;
               state_ff               <= ST_STALE;
            end
            tf_pkg::REG_KEY_LENGTH: begin
               len_ff   <= csr_wdata[5:0];
               state_ff <= ST_STALE;
            end
            default: begin
            end
         endcase
      end else begin
         unique case (state_ff)
            ST_STALE: begin
               state_ff <= ST_RUN;
               cnt_ff   <= '0;
            end
            ST_RUN: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(tf_pkg::NUM_KEY_PAIRS - 1)) begin
                  state_ff <= ST_READY;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_STALE) begin
         kcode_ff <= kcode;
         sbox_ff  <= sbox_in;
      end
      if (state_ff == ST_RUN) begin
         for (int j = 0; j < tf_pkg::NUM_SUBKEYS - 2; j++) begin
            rk_ff[j] <= rk_ff[j+2];
         end
         rk_ff[tf_pkg::NUM_SUBKEYS-2] <= sum_ab;
         rk_ff[tf_pkg::NUM_SUBKEYS-1] <= sum_a2b;
      end
   end

   always_comb begin
      ks.valid = (state_ff == ST_READY);
      ks.busy  = (state_ff == ST_RUN);
      ks.kcode = kcode_ff;
      ks.sbox  = sbox_ff;
      for (int j = 0; j < tf_pkg::NUM_SUBKEYS; j++) begin
         round_keys[j] = rk_ff[j];
      end
   end

endmodule

// ===== design/tf_round_cell.sv =====
// one twofish round with its pipeline register, either direction
// uses tf_pkg for the g function and the stage type
module tf_round_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tf_pkg::stage_type     in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output tf_pkg::stage_type     out_data,
   input  logic                  out_ready,
   input  tf_pkg::key_state_type ks,
   input  logic [31:0]           key_enc_even,
   input  logic [31:0]           key_enc_odd,
   input  logic [31:0]           key_dec_even,
   input  logic [31:0]           key_dec_odd
);

   logic              valid_ff;
   tf_pkg::stage_type data_ff;
   tf_pkg::stage_type data_in;
   logic [31:0]       t0, t1, f0, f1, k_even, k_odd;

   always_comb begin
      k_even = in_data.op ? key_dec_even : key_enc_even;
      k_odd  = in_data.op ? key_dec_odd  : key_enc_odd;
      t0 = tf_pkg::h_fn(in_data.w[0], ks.sbox[0], ks.sbox[1], ks.sbox[2], ks.sbox[3],
                        ks.kcode);
      t1 = tf_pkg::h_fn(tf_pkg::rotl32(in_data.w[1], 8), ks.sbox[0], ks.sbox[1],
                        ks.sbox[2], ks.sbox[3], ks.kcode);
      f0 = t0 + t1 + k_even;
      f1 = t0 + {t1[30:0], 1'b0} + k_odd;
      data_in.op   = in_data.op;
      data_in.w[2] = in_data.w[0];
      data_in.w[3] = in_data.w[1];
      if (in_data.op) begin
         data_in.w[0] = tf_pkg::rotl32(in_data.w[2], 1) ^ f0;
         data_in.w[1] = tf_pkg::rotr32(in_data.w[3] ^ f1, 1);
      end else begin
         data_in.w[0] = tf_pkg::rotr32(in_data.w[2] ^ f0, 1);
         data_in.w[1] = tf_pkg::rotl32(in_data.w[3], 1) ^ f1;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
